FILE: rtl/mwed_pkg.sv
// shared constants, types and helpers for the motion window event detector
package mwed_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int SAMPLE_BITS  = 16;

	localparam int IDX_W   = $clog2(WINDOW_DEPTH);
	localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int DELTA_W = SAMPLE_BITS;
	localparam int STR_W   = DELTA_W + 2;

	localparam int MIN_W     = 16;
	localparam int THR_W     = 5;
	localparam int NOISE_W   = 18;
	localparam int CFG_W     = 18;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_CNT_W = 5;

	localparam int MCMP_W = (DELTA_W > MIN_W) ? DELTA_W : MIN_W;
	localparam int SCMP_W = (STR_W > NOISE_W) ? STR_W : NOISE_W;
	localparam int CCMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

	localparam int IN_TDATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 2 + 2 * OUT_CNT_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_THR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE     = 3'd4;

	typedef struct packed {
		logic [DELTA_W-1:0] dz;
		logic [DELTA_W-1:0] dy;
		logic [DELTA_W-1:0] dx;
	} delta_t;

	typedef struct packed {
		logic [MIN_W-1:0]   min_x;
		logic [MIN_W-1:0]   min_y;
		logic [MIN_W-1:0]   min_z;
		logic [NOISE_W-1:0] noise;
	} limits_t;

	function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
		logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
		if (sum >= (CNT_W + 1)'(WINDOW_DEPTH)) begin
			sum = sum - (CNT_W + 1)'(WINDOW_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

FILE: rtl/mwed_match_unit.sv
// shared per-entry evaluation unit: strength sum and limit compares, registered
module mwed_match_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  mwed_pkg::delta_t  entry,
	input  mwed_pkg::limits_t lim,
	output logic              hit_valid,
	output logic              hit
);

	logic [mwed_pkg::STR_W-1:0] strength;
	logic                       above_noise;
	logic                       axes_ok;
	logic                       hit_valid_s2;
	logic                       hit_s2;

	always_comb begin
		strength = mwed_pkg::STR_W'(entry.dx) + mwed_pkg::STR_W'(entry.dy)
			+ mwed_pkg::STR_W'(entry.dz);
		above_noise = mwed_pkg::SCMP_W'(strength) > mwed_pkg::SCMP_W'(lim.noise);
		axes_ok = (mwed_pkg::MCMP_W'(entry.dx) >= mwed_pkg::MCMP_W'(lim.min_x))
			&& (mwed_pkg::MCMP_W'(entry.dy) >= mwed_pkg::MCMP_W'(lim.min_y))
			&& (mwed_pkg::MCMP_W'(entry.dz) >= mwed_pkg::MCMP_W'(lim.min_z));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid_s2 <= 1'b0;
		end else begin
			hit_valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_s2 <= above_noise && axes_ok;
	end

	assign hit_valid = hit_valid_s2;
	assign hit       = hit_s2;

endmodule

FILE: rtl/motion_window_event_detector_core.sv
// motion window event detector: sequencer, delta window memory and result register
//
// s_tdata carries one accelerometer sample word: accel_x, accel_y, accel_z,
// each a signed 16-bit field, lowest bits first. m_tdata carries one result
// word per sample: motion_flag, delta_formed, match_count, window_fill.
// Limits are set through cfg_we / cfg_index / cfg_data by the user while the
// block idles; the block itself does not enforce this. The first sample after
// reset only primes the previous sample and returns delta_formed low with the
// motion flag unchanged. Each later sample forms absolute deltas, writes them
// into a 16-entry window memory and scans the held entries one per cycle
// through a single evaluation unit; the memory read port and that unit set the
// timing. The result is registered in FINISH, reached straight after accept
// for the first sample and through WRITE, SCAN and DRAIN otherwise; s_tready
// is low meanwhile and rises with m_tvalid, so a new sample is taken only
// once the last result is registered. The result sits in an output register,
// so the next sample is accepted while it waits; a stalled m_tready only
// holds back completion of the following sample. Reset clears the previous
// sample, window fill, head pointer, motion flag and limits; no memory
// clearing pass is needed.
module motion_window_event_detector_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [mwed_pkg::IN_TDATA_W-1:0]    s_tdata,   // accel_x, accel_y, accel_z
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [mwed_pkg::OUT_TDATA_W-1:0]   m_tdata,   // motion_flag, delta_formed, match_count, window_fill
	input  logic                               cfg_we,
	input  logic [mwed_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mwed_pkg::CFG_W-1:0]         cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WRITE  = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	localparam int SB = mwed_pkg::SAMPLE_BITS;

	function automatic logic [mwed_pkg::DELTA_W-1:0] abs_diff(logic [SB-1:0] a,
		logic [SB-1:0] b);
		logic [SB:0] d;
		d = {a[SB-1], a} - {b[SB-1], b};
		if (d[SB]) begin
			d = -d;
		end
		return d[mwed_pkg::DELTA_W-1:0];
	endfunction

	logic [2:0]                      state_q;
	logic [mwed_pkg::MIN_W-1:0]      min_x_q, min_y_q, min_z_q;
	logic [mwed_pkg::THR_W-1:0]      thr_q;
	logic [mwed_pkg::NOISE_W-1:0]    noise_q;
	logic [SB-1:0]                   prev_x_q, prev_y_q, prev_z_q;
	logic                            have_prev_q;
	logic [mwed_pkg::IDX_W-1:0]      head_q;
	logic [mwed_pkg::CNT_W-1:0]      count_q;
	logic [mwed_pkg::CNT_W-1:0]      idx_q;
	logic [mwed_pkg::CNT_W-1:0]      match_q;
	logic                            motion_q;
	logic                            formed_q;
	mwed_pkg::delta_t                delta_q;
	logic                            out_valid_q;
	logic [mwed_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic [$bits(mwed_pkg::delta_t)-1:0] mem [mwed_pkg::WINDOW_DEPTH];
	logic [$bits(mwed_pkg::delta_t)-1:0] rd_data_s1;
	logic                            rd_valid_s1;

	logic [SB-1:0]                   cur_x, cur_y, cur_z;
	logic                            accept;
	logic                            full;
	logic                            mem_we;
	logic [mwed_pkg::IDX_W-1:0]      wr_slot;
	logic                            rd_en;
	logic [mwed_pkg::IDX_W-1:0]      rd_addr;
	logic                            out_free;
	logic                            new_motion;
	mwed_pkg::limits_t               lim;
	logic                            hit_valid;
	logic                            hit;

	assign cur_x = s_tdata[SB-1:0];
	assign cur_y = s_tdata[2*SB-1:SB];
	assign cur_z = s_tdata[3*SB-1:2*SB];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == mwed_pkg::CNT_W'(mwed_pkg::WINDOW_DEPTH));
	assign mem_we   = (state_q == ST_WRITE);
	assign wr_slot  = full ? head_q : mwed_pkg::wrap_add(head_q, count_q);
	assign rd_en    = (state_q == ST_SCAN);
	assign rd_addr  = mwed_pkg::wrap_add(head_q, idx_q);
	assign out_free = !out_valid_q || m_tready;

	assign new_motion = formed_q
		? (mwed_pkg::CCMP_W'(match_q) >= mwed_pkg::CCMP_W'(thr_q))
		: motion_q;

	assign lim.min_x = min_x_q;
	assign lim.min_y = min_y_q;
	assign lim.min_z = min_z_q;
	assign lim.noise = noise_q;

	mwed_match_unit u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_valid_s1),
		.entry     (mwed_pkg::delta_t'(rd_data_s1)),
		.lim       (lim),
		.hit_valid (hit_valid),
		.hit       (hit)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_slot] <= delta_q;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			min_y_q <= '0;
			min_z_q <= '0;
			thr_q   <= mwed_pkg::THR_W'(1);
			noise_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mwed_pkg::REG_MIN_X:     min_x_q <= cfg_data[mwed_pkg::MIN_W-1:0];
				mwed_pkg::REG_MIN_Y:     min_y_q <= cfg_data[mwed_pkg::MIN_W-1:0];
				mwed_pkg::REG_MIN_Z:     min_z_q <= cfg_data[mwed_pkg::MIN_W-1:0];
				mwed_pkg::REG_COUNT_THR: thr_q   <= cfg_data[mwed_pkg::THR_W-1:0];
				mwed_pkg::REG_NOISE:     noise_q <= cfg_data[mwed_pkg::NOISE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q.dx <= abs_diff(prev_x_q, cur_x);
			delta_q.dy <= abs_diff(prev_y_q, cur_y);
			delta_q.dz <= abs_diff(prev_z_q, cur_z);
			formed_q   <= have_prev_q;
		end
		if (state_q == ST_FINISH && out_free) begin
			out_data_q <= mwed_pkg::OUT_TDATA_W'({
				mwed_pkg::OUT_CNT_W'(count_q),
				mwed_pkg::OUT_CNT_W'(match_q),
				formed_q,
				new_motion});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_z_q    <= '0;
			have_prev_q <= 1'b0;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			match_q     <= '0;
			motion_q    <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (hit_valid && hit) begin
				match_q <= match_q + mwed_pkg::CNT_W'(1);
			end
			if (out_valid_q && m_tready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_x_q    <= cur_x;
						prev_y_q    <= cur_y;
						prev_z_q    <= cur_z;
						have_prev_q <= 1'b1;
						match_q     <= '0;
						state_q     <= have_prev_q ? ST_WRITE : ST_FINISH;
					end
				end
				ST_WRITE: begin
					if (full) begin
						head_q <= mwed_pkg::wrap_add(head_q, mwed_pkg::CNT_W'(1));
					end else begin
						count_q <= count_q + mwed_pkg::CNT_W'(1);
					end
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					idx_q <= idx_q + mwed_pkg::CNT_W'(1);
					if (idx_q == count_q - mwed_pkg::CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_valid_s1 && !hit_valid) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						motion_q    <= new_motion;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: rtl/mwed_checker.sv
// port-level checker for the motion window event detector, bound to the top level
module mwed_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [mwed_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int OC = mwed_pkg::OUT_CNT_W;

	logic [OC-1:0] o_match;
	logic [OC-1:0] o_fill;

	assign o_match = m_tdata[2+OC-1:2];
	assign o_fill  = m_tdata[2+2*OC-1:2+OC];

	// one word at a time: busy right after a sample is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again right after accept");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result word changed");

	a_match_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (o_match <= o_fill))
		else $error("match count above window fill");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (o_fill <= OC'(mwed_pkg::WINDOW_DEPTH)))
		else $error("window fill above depth");

	a_prime_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[1]) |-> (o_match == '0))
		else $error("match count without a formed delta");

endmodule

bind motion_window_event_detector_core mwed_checker u_mwed_checker (.*);
